### rtl/lru_page_buffer_assert.svh
// ----------------------------------------------------------------------------
// lru_page_buffer_assert.svh
// Assertion macros shared by the page buffer checker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_BUFFER_ASSERT_SVH
`define LRU_PAGE_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and quiet during reset.
`define LPB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and quiet during reset.
`define LPB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpb_pkg
// Types and constants shared by the page buffer cells and the top level.
// ----------------------------------------------------------------------------
package lpb_pkg;

    // Position fields are wide enough for the largest supported buffer.
    localparam int POS_W = 6;
    localparam int CNT_W = 7;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam logic REG_TREE_HEIGHT = 1'b0;
    localparam logic [3:0] TREE_HEIGHT_RST = 4'd3;

    // Commands.
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One buffered page.
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] payload;
        logic        dirty;
    } entry_t;

    // Broadcast from the sequencer to every cell for one update cycle.
    // front: cell 0 takes fresh, cells 1..hi take their front neighbour.
    // back:  cell hi takes fresh, cells lo..hi-1 take their back neighbour.
    typedef struct packed {
        logic   front;
        logic   back;
        pos_t   lo;
        pos_t   hi;
        entry_t fresh;
    } ctrl_t;

endpackage
`default_nettype wire

### rtl/lpb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpb_cell
// One position of the recency list: holds an entry, compares its key and
// shifts towards either neighbour under the broadcast control word.
// ----------------------------------------------------------------------------
module lpb_cell #(
    parameter int IDX = 0
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire lpb_pkg::ctrl_t ctrl,
    input  wire lpb_pkg::entry_t prev_entry,
    input  wire lpb_pkg::entry_t next_entry,
    input  wire logic [31:0]    cmp_key,
    input  wire lpb_pkg::cnt_t  fill,
    output lpb_pkg::entry_t     entry,
    output logic                match
);
    import lpb_pkg::*;

    localparam pos_t MY_POS = POS_W'(IDX);
    localparam cnt_t MY_CNT = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;

    // Select the new content of this position.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.front) begin
            if (MY_POS == '0) begin
                entry_next = ctrl.fresh;
            end else if (MY_POS <= ctrl.hi) begin
                entry_next = prev_entry;
            end
        end else if (ctrl.back) begin
            if (MY_POS == ctrl.hi) begin
                entry_next = ctrl.fresh;
            end else if ((MY_POS >= ctrl.lo) && (MY_POS < ctrl.hi)) begin
                entry_next = next_entry;
            end
        end
    end

    // The dirty mark is cleared at reset; key and payload need no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.dirty <= 1'b0;
        end else begin
            entry_reg.dirty <= entry_next.dirty;
        end
        entry_reg.key     <= entry_next.key;
        entry_reg.payload <= entry_next.payload;
    end

    // Only occupied positions take part in the lookup.
    assign match = (entry_reg.key == cmp_key) && (MY_CNT < fill);
    assign entry = entry_reg;

endmodule
`default_nettype wire

### rtl/lru_page_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_buffer
// Recency-ordered write-back page buffer built from a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on the s_ channel (put or get of one page, keyed by
//   s_page_offset); one result word leaves on the m_ channel per request.
//   The APB port holds tree_height (capacity minus one) at address 0.
//   Timing: a word accepted on the s_ channel is compared by every cell in
//   the match cycle, and the chain shifts in the update cycle, which also
//   loads the result into the output register. A new word is taken in the
//   shifting cycle of the word before it; each word passes the lookup cycle
//   and then the one-step shift through the cell chain.
//   The result sits in an output register; if the receiver stalls, the
//   block still accepts the next word and finishes its lookup, then holds
//   in the shift cycle until the output register is free.
//   Reset empties the buffer at once (fill count to zero, dirty marks
//   cleared) and sets tree_height to 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_page_buffer #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // request channel
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_command,
    input  wire logic [31:0]                s_page_offset,
    input  wire logic [63:0]                s_page_data,
    input  wire logic                       s_is_write,
    input  wire logic                       s_low_priority,
    // result channel
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_hit,
    output logic [63:0]                     m_read_data,
    output logic                            m_writeback_valid,
    output logic [31:0]                     m_writeback_offset,
    output logic [63:0]                     m_writeback_data,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lpb_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lpb_pkg::*;

    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int CMP_W = (CW > 5) ? CW : 5;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [3:0]             th_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] match_w;

    // Held request word.
    logic        cmd_reg;
    logic [31:0] key_reg;
    logic [63:0] data_reg;
    logic        wr_reg;
    logic        low_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_hit_reg;
    logic [63:0] out_rdata_reg;
    logic        out_wb_reg;
    logic [31:0] out_wb_key_reg;
    logic [63:0] out_wb_data_reg;

    entry_t cell_q [MAX_ENTRIES];
    ctrl_t  ctrl;

    logic          accept;
    logic          out_free;
    logic          do_update;
    logic          hit;
    logic [IW-1:0] pos;
    logic [63:0]   sel_payload;
    logic          sel_dirty;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] last_idx;
    entry_t        last_entry;
    logic [4:0]    cap;
    logic          full;
    logic          evict;
    logic [CW-1:0] n_after;
    logic          reg_sel;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    assign reg_sel = paddr[APB_AW-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == REG_TREE_HEIGHT) ? {28'd0, th_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_reg <= TREE_HEIGHT_RST;
        end else if (psel && penable && pwrite && pready && (reg_sel == REG_TREE_HEIGHT)) begin
            th_reg <= pwdata[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || m_ready;
    assign do_update = (state_reg == ST_UPDATE) && out_free;
    assign s_ready   = (state_reg == ST_IDLE) || do_update;
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = accept ? ST_MATCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Request word is captured on acceptance.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_command;
            key_reg  <= s_page_offset;
            data_reg <= s_page_data;
            wr_reg   <= s_is_write;
            low_reg  <= s_low_priority;
        end
    end

    // Lookup result of all cells is registered in the match cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MATCH) begin
            match_reg <= match_w;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        entry_t prev_e;
        entry_t next_e;

        if (g == 0) begin : g_head
            assign prev_e = ctrl.fresh;
        end else begin : g_body
            assign prev_e = cell_q[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_inner
            assign next_e = cell_q[g+1];
        end

        lpb_cell #(
            .IDX (g)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .cmp_key    (key_reg),
            .fill       (CNT_W'(count_reg)),
            .entry      (cell_q[g]),
            .match      (match_w[g])
        );
    end

    // ------------------------------------------------------------------
    // Hit position and hit entry from the one-hot match vector
    // ------------------------------------------------------------------
    always_comb begin
        pos         = '0;
        sel_payload = '0;
        sel_dirty   = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_reg[i]) begin
                pos = pos | IW'(i);
            end
            sel_payload = sel_payload | ({64{match_reg[i]}} & cell_q[i].payload);
            sel_dirty   = sel_dirty | (match_reg[i] & cell_q[i].dirty);
        end
    end

    assign hit        = |match_reg;
    assign cnt_m1     = count_reg - CW'(1);
    assign last_idx   = cnt_m1[IW-1:0];
    assign last_entry = cell_q[last_idx];

    // Buffer is full when the fill reaches the capacity or the store size.
    assign cap     = {1'b0, th_reg} + 5'd1;
    assign full    = (CMP_W'(count_reg) >= CMP_W'(cap)) ||
                     (count_reg == CW'(MAX_ENTRIES));
    assign evict   = (cmd_reg == CMD_PUT) && !hit && full && (count_reg != '0);
    assign n_after = evict ? cnt_m1 : count_reg;

    // ------------------------------------------------------------------
    // Control word for the shift cycle
    // ------------------------------------------------------------------
    always_comb begin
        ctrl               = '0;
        ctrl.fresh.key     = key_reg;
        ctrl.fresh.payload = data_reg;
        ctrl.fresh.dirty   = wr_reg;
        count_next         = count_reg;
        if (do_update) begin
            if (cmd_reg == CMD_GET) begin
                // A get hit moves the page to the front unless low priority.
                if (hit && !low_reg) begin
                    ctrl.front         = 1'b1;
                    ctrl.hi            = POS_W'(pos);
                    ctrl.fresh.payload = sel_payload;
                    ctrl.fresh.dirty   = sel_dirty;
                end
            end else if (hit) begin
                // A put hit replaces the payload and keeps a set dirty mark.
                ctrl.fresh.dirty = sel_dirty | wr_reg;
                if (low_reg) begin
                    ctrl.back = 1'b1;
                    ctrl.lo   = POS_W'(pos);
                    ctrl.hi   = POS_W'(last_idx);
                end else begin
                    ctrl.front = 1'b1;
                    ctrl.hi    = POS_W'(pos);
                end
            end else begin
                // A put miss drops the tail when full, then inserts.
                if (low_reg) begin
                    ctrl.back = 1'b1;
                    ctrl.lo   = POS_W'(n_after);
                    ctrl.hi   = POS_W'(n_after);
                end else begin
                    ctrl.front = 1'b1;
                    ctrl.hi    = POS_W'(n_after);
                end
                count_next = n_after + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (do_update) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            out_hit_reg     <= hit;
            out_rdata_reg   <= ((cmd_reg == CMD_GET) && hit) ? sel_payload : 64'd0;
            out_wb_reg      <= evict && last_entry.dirty;
            out_wb_key_reg  <= (evict && last_entry.dirty) ? last_entry.key : 32'd0;
            out_wb_data_reg <= (evict && last_entry.dirty) ? last_entry.payload : 64'd0;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_hit              = out_hit_reg;
    assign m_read_data        = out_rdata_reg;
    assign m_writeback_valid  = out_wb_reg;
    assign m_writeback_offset = out_wb_key_reg;
    assign m_writeback_data   = out_wb_data_reg;

endmodule
`default_nettype wire

### rtl/lpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpb_checker
// Port-level checks on the page buffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "lru_page_buffer_assert.svh"

module lpb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_hit,
    input wire logic [63:0] m_read_data,
    input wire logic        m_writeback_valid,
    input wire logic [31:0] m_writeback_offset,
    input wire logic [63:0] m_writeback_data
);

    // A stalled result word keeps its read data.
    `LPB_ASSERT_NXT(a_out_hold, m_valid && !m_ready,
                    m_valid && $stable(m_read_data), "result changed while stalled")

    // Writeback fields are zero unless a writeback is reported.
    `LPB_ASSERT_IMP(a_wb_zero, m_valid && !m_writeback_valid,
                    (m_writeback_offset == 32'd0) && (m_writeback_data == 64'd0),
                    "writeback fields set without writeback")

    // Read data only comes from a hit.
    `LPB_ASSERT_IMP(a_rdata_hit, m_valid && (m_read_data != 64'd0), m_hit,
                    "read data without hit")

    // Eviction only happens on a miss.
    `LPB_ASSERT_IMP(a_wb_miss, m_valid && m_writeback_valid, !m_hit,
                    "writeback reported on a hit")

    // The lookup cycle after acceptance never takes another word.
    `LPB_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready,
                    "request taken during lookup")

endmodule

bind lru_page_buffer lpb_checker u_lpb_checker (.*);
`default_nettype wire

### verif/tb_lru_page_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_buffer
// Self-checking testbench for the recency-ordered write-back page buffer.
// ----------------------------------------------------------------------------
// Request words are driven on the s_ channel. Each accepted word is run
// through a local model of the recency list, which yields the result word
// the block must return; results are checked in order on the m_ channel.
// A directed part covers empty-buffer lookups, hits and misses, low-priority
// placement, clean and dirty evictions and a capacity cut below the fill.
// Random phases follow at several capacities, with random gaps on both sides,
// a stretch without gaps, a long output stall and a full pause of the sender.
// ----------------------------------------------------------------------------
module tb_lru_page_buffer;

    import lpb_pkg::*;

    localparam int BUFFER_DEPTH  = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int IDLE_MAX      = 14;
    localparam logic [APB_AW-1:0] TREE_HEIGHT_ADDR = APB_AW'(4 * REG_TREE_HEIGHT);

    // One request word and one result word, as the ports carry them.
    typedef struct packed {
        logic        command;
        logic [31:0] offset;
        logic [63:0] data;
        logic        is_write;
        logic        low_priority;
    } page_request_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_data;
        logic        wb_valid;
        logic [31:0] wb_offset;
        logic [63:0] wb_data;
    } page_result_t;

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_command      = CMD_PUT;
    logic [31:0]         s_page_offset  = '0;
    logic [63:0]         s_page_data    = '0;
    logic                s_is_write     = 1'b0;
    logic                s_low_priority = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_hit;
    logic [63:0]         m_read_data;
    logic                m_writeback_valid;
    logic [31:0]         m_writeback_offset;
    logic [63:0]         m_writeback_data;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [31:0]         pwdata         = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Local copy of the recency list, front at index 0.
    entry_t              page_store [BUFFER_DEPTH];
    int unsigned         fill_count      = 0;
    logic [3:0]          cfg_tree_height = TREE_HEIGHT_RST;

    page_result_t        expected_results [$];
    logic [31:0]         key_pool [$];
    int unsigned         mismatch_count   = 0;
    int unsigned         result_index     = 0;
    int unsigned         send_gap_max     = IDLE_MAX;
    int unsigned         recv_stall_max   = IDLE_MAX;
    int unsigned         hold_off_request = 0;

    lru_page_buffer #(
        .MAX_ENTRIES(BUFFER_DEPTH)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_page_offset     (s_page_offset),
        .s_page_data       (s_page_data),
        .s_is_write        (s_is_write),
        .s_low_priority    (s_low_priority),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_read_data       (m_read_data),
        .m_writeback_valid (m_writeback_valid),
        .m_writeback_offset(m_writeback_offset),
        .m_writeback_data  (m_writeback_data),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 50 MHz clock.
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Recency list model
    // ------------------------------------------------------------------------

    // Drop one position and close the gap behind it.
    function automatic void remove_entry(int unsigned pos);
        for (int unsigned i = pos; i + 1 < fill_count; i++) begin
            page_store[i] = page_store[i + 1];
        end
        fill_count--;
    endfunction

    // Place an entry at the front or at the back of the list.
    function automatic void insert_entry(entry_t ent, logic at_back);
        if (at_back) begin
            page_store[fill_count] = ent;
        end else begin
            for (int unsigned i = fill_count; i > 0; i--) begin
                page_store[i] = page_store[i - 1];
            end
            page_store[0] = ent;
        end
        fill_count++;
    endfunction

    // Apply one request to the list and return the result it produces.
    function automatic page_result_t predict_access(page_request_t rq);
        page_result_t res;
        entry_t       moved;
        int unsigned  capacity;
        int           pos;
        res      = '0;
        capacity = int'(cfg_tree_height) + 1;
        if (capacity > BUFFER_DEPTH) begin
            capacity = BUFFER_DEPTH;
        end
        pos = -1;
        for (int i = 0; i < int'(fill_count); i++) begin
            if (pos < 0 && page_store[i].key == rq.offset) begin
                pos = i;
            end
        end
        if (rq.command == CMD_GET) begin
            if (pos >= 0) begin
                res.hit       = 1'b1;
                res.read_data = page_store[pos].payload;
                if (!rq.low_priority) begin
                    moved = page_store[pos];
                    remove_entry(pos);
                    insert_entry(moved, 1'b0);
                end
            end
        end else if (pos >= 0) begin
            // A dirty mark, once set, survives a clean rewrite.
            moved.key     = rq.offset;
            moved.payload = rq.data;
            moved.dirty   = page_store[pos].dirty | rq.is_write;
            res.hit       = 1'b1;
            remove_entry(pos);
            insert_entry(moved, rq.low_priority);
        end else begin
            // A miss on a full list evicts the back entry, dirty or not.
            if (fill_count >= capacity && fill_count > 0) begin
                if (page_store[fill_count - 1].dirty) begin
                    res.wb_valid  = 1'b1;
                    res.wb_offset = page_store[fill_count - 1].key;
                    res.wb_data   = page_store[fill_count - 1].payload;
                end
                fill_count--;
            end
            moved.key     = rq.offset;
            moved.payload = rq.data;
            moved.dirty   = rq.is_write;
            insert_entry(moved, rq.low_priority);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers and result checker
    // ------------------------------------------------------------------------

    // Offer one request word after a random gap and log its expected result.
    task automatic send_request(input page_request_t rq);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= rq.command;
        s_page_offset  <= rq.offset;
        s_page_data    <= rq.data;
        s_is_write     <= rq.is_write;
        s_low_priority <= rq.low_priority;
        do @(posedge aclk); while (!s_ready);
        expected_results.insert(expected_results.size(), predict_access(rq));
    endtask

    function automatic page_request_t make_request(logic cmd, logic [31:0] offset,
                                                   logic [63:0] data, logic wr,
                                                   logic low);
        page_request_t rq;
        rq.command      = cmd;
        rq.offset       = offset;
        rq.data         = data;
        rq.is_write     = wr;
        rq.low_priority = low;
        return rq;
    endfunction

    // Mostly keys from the pool so that hits occur; now and then a fresh key.
    function automatic page_request_t random_request();
        logic [31:0] offset;
        if ($urandom_range(0, 15) == 0 || key_pool.size() == 0) begin
            offset = $urandom;
        end else begin
            offset = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        return make_request(($urandom_range(0, 9) < 4) ? CMD_GET : CMD_PUT, offset,
                            {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) == 0));
    endfunction

    // Result receiver: a random stall per word, plus an optional long hold-off.
    initial begin : result_receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                stall_left = $urandom_range(0, recv_stall_max);
            end
            if (hold_off_request > 0) begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge aclk) begin : result_checker
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (m_hit !== want.hit)
                    report_mismatch($sformatf("word %0d hit %0b, want %0b",
                                              result_index, m_hit, want.hit));
                if (m_read_data !== want.read_data)
                    report_mismatch($sformatf("word %0d read_data %h, want %h",
                                              result_index, m_read_data, want.read_data));
                if (m_writeback_valid !== want.wb_valid)
                    report_mismatch($sformatf("word %0d writeback_valid %0b, want %0b",
                                              result_index, m_writeback_valid,
                                              want.wb_valid));
                if (m_writeback_offset !== want.wb_offset)
                    report_mismatch($sformatf("word %0d writeback_offset %h, want %h",
                                              result_index, m_writeback_offset,
                                              want.wb_offset));
                if (m_writeback_data !== want.wb_data)
                    report_mismatch($sformatf("word %0d writeback_data %h, want %h",
                                              result_index, m_writeback_data,
                                              want.wb_data));
            end
            result_index++;
        end
    end

    // Stop offering words and wait until every result is back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write tree_height while idle, then read it back.
    task automatic set_tree_height(input logic [3:0] height);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TREE_HEIGHT_ADDR;
        pwdata  <= {28'd0, height};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cfg_tree_height = height;
        // Keep psel high and go straight into the read setup phase.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {28'd0, height})
            report_mismatch($sformatf("tree_height read %h, want %h", prdata, height));
        psel    <= 1'b0;
        penable <= 1'b0;
        repeat (2) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    localparam logic [31:0] KEY_LOW  = 32'h0000_0000;
    localparam logic [31:0] KEY_HIGH = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_A    = 32'h1234_5678;
    localparam logic [31:0] KEY_B    = 32'h8000_0001;
    localparam logic [31:0] KEY_C    = 32'h5A5A_A5A5;
    localparam logic [31:0] KEY_D    = 32'h0F0F_F0F0;

    // Hits, misses, placement and evictions at the reset capacity of four.
    task automatic test_directed_basic();
        // Lookups on an empty buffer.
        send_request(make_request(CMD_GET, KEY_LOW, '1, 1'b1, 1'b0));
        send_request(make_request(CMD_GET, KEY_HIGH, '0, 1'b0, 1'b1));
        // Fill to capacity, one entry placed at the back.
        send_request(make_request(CMD_PUT, KEY_LOW, '0, 1'b1, 1'b0));
        send_request(make_request(CMD_PUT, KEY_HIGH, '1, 1'b0, 1'b0));
        send_request(make_request(CMD_PUT, KEY_A, {$urandom, $urandom}, 1'b1, 1'b1));
        send_request(make_request(CMD_PUT, KEY_B, {$urandom, $urandom}, 1'b0, 1'b0));
        // Get hits, with and without reordering.
        send_request(make_request(CMD_GET, KEY_LOW, '1, 1'b0, 1'b0));
        send_request(make_request(CMD_GET, KEY_A, '0, 1'b1, 1'b1));
        // Put hits: mark dirty, then a clean rewrite that keeps the mark.
        send_request(make_request(CMD_PUT, KEY_B, {$urandom, $urandom}, 1'b1, 1'b0));
        send_request(make_request(CMD_PUT, KEY_B, '1, 1'b0, 1'b1));
        send_request(make_request(CMD_PUT, KEY_HIGH, '0, 1'b0, 1'b0));
        // Misses on a full buffer: a mix of clean and dirty evictions.
        send_request(make_request(CMD_PUT, KEY_C, '1, 1'b1, 1'b0));
        send_request(make_request(CMD_PUT, KEY_D, {$urandom, $urandom}, 1'b0, 1'b1));
        send_request(make_request(CMD_PUT, ~KEY_A, {$urandom, $urandom}, 1'b1, 1'b0));
        send_request(make_request(CMD_PUT, ~KEY_B, {$urandom, $urandom}, 1'b1, 1'b0));
        send_request(make_request(CMD_GET, KEY_C, '0, 1'b0, 1'b0));
        send_request(make_request(CMD_GET, KEY_A, '0, 1'b0, 1'b0));
    endtask

    // Capacity cut below the current fill: misses swap entries one for one.
    task automatic test_capacity_shrink();
        set_tree_height(4'd0);
        send_request(make_request(CMD_PUT, ~KEY_C, '1, 1'b1, 1'b1));
        send_request(make_request(CMD_PUT, ~KEY_D, '0, 1'b0, 1'b0));
        send_request(make_request(CMD_GET, KEY_C, '0, 1'b0, 1'b1));
        send_request(make_request(CMD_GET, ~KEY_D, '1, 1'b0, 1'b0));
        send_request(make_request(CMD_PUT, KEY_C, '1, 1'b1, 1'b0));
    endtask

    // Random traffic over a key pool sized against the capacity.
    task automatic test_random_traffic(input logic [3:0] height, input int unsigned items,
                                       input int unsigned pool_size);
        set_tree_height(height);
        key_pool.delete();
        for (int unsigned i = 0; i < pool_size; i++) begin
            key_pool.insert(key_pool.size(), $urandom);
        end
        for (int unsigned i = 0; i < items; i++) begin
            send_request(random_request());
        end
    endtask

    // No gaps on either side for a whole phase.
    task automatic test_back_to_back();
        send_gap_max   = 0;
        recv_stall_max = 0;
        test_random_traffic(4'd7, 150, 12);
        wait_for_results();
        send_gap_max   = IDLE_MAX;
        recv_stall_max = IDLE_MAX;
    endtask

    // The receiver holds off while the sender keeps offering words.
    task automatic test_output_stall();
        wait_for_results();
        send_gap_max     = 0;
        hold_off_request = 300;
        for (int unsigned i = 0; i < 40; i++) begin
            send_request(random_request());
        end
        send_gap_max = IDLE_MAX;
    endtask

    // The sender pauses until every result is back, then resumes.
    task automatic test_sender_pause();
        for (int unsigned i = 0; i < 30; i++) begin
            send_request(random_request());
        end
        wait_for_results();
        for (int unsigned i = 0; i < 30; i++) begin
            send_request(random_request());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_basic();
        test_capacity_shrink();
        test_random_traffic(4'd15, 400, 24);
        test_random_traffic(4'd0, 150, 3);
        test_random_traffic(4'd3, 330, 8);
        test_random_traffic(4'($urandom_range(1, 14)), 250, 14);
        test_back_to_back();
        test_output_stall();
        test_sender_pause();

        // Let the last results drain, within a bound.
        s_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++) begin
            @(posedge aclk);
        end
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
